[hw/rtl/itm_pkg.sv]
`default_nettype none

package itm_pkg;

   // Tile geometry
   localparam int TILE_SIZE        = 5;
   localparam int MAX_TILES_ACROSS = 256;
   localparam int TILE_AREA        = TILE_SIZE * TILE_SIZE;

   // Fixed field widths
   localparam int PIXEL_W  = 8;
   localparam int COLUMN_W = 8;
   localparam int ROW_W    = 10;
   localparam int CFG_W    = 9;

   localparam logic [CFG_W-1:0]   TILES_RESET = CFG_W'(140);
   localparam logic [PIXEL_W-1:0] FULL_SCALE  = PIXEL_W'(255);

   // Derived widths
   localparam int CNT_W  = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
   localparam int TC_W   = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
   localparam int SUM_W  = $clog2(TILE_AREA * 255 + 1);
   localparam int AREA_LOG = $clog2(TILE_AREA);

   // Exact floor(sum / area) by reciprocal: ceil(2^K / area) with K = SUM_W + ceil(log2(area))
   localparam int RECIP_K = SUM_W + AREA_LOG;
   localparam int RECIP_W = SUM_W + 1;
   localparam int MEAN_W  = SUM_W - AREA_LOG + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_K) + 64'(TILE_AREA) - 64'd1) / 64'(TILE_AREA));

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  tile_value;
      logic [COLUMN_W-1:0] tile_column;
      logic [ROW_W-1:0]    tile_row;
      logic                row_done;
   } rsp_type;

   // Completed tile on its way to the output stage
   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                last;
   } tile_sum_type;

endpackage

`default_nettype wire

[hw/rtl/inverted_tile_mean.sv]
// Inverted tile mean over a grey pixel stream.
// req_*: one 8-bit pixel per transfer in raster order; frame_start on the first
//   pixel of a frame clears all position counters before that pixel counts.
// rsp_*: one transfer per finished tile, issued on the tile's bottom-right pixel:
//   255 minus the truncated tile mean, tile column, tile row and a last-in-row flag.
// csr_*: write of tiles_across (tiles per image row); csr_ready is always high.
//   Write it only while no pixel is in flight.
// Throughput: one pixel per clock unless the output stalls. The per-column sum
//   store is read when a pixel is taken and written back as it leaves the pixel
//   register, with a bypass when neighboring pixels hit the same tile column.
// Path: a tile's last pixel is loaded into the pixel register when taken, then its sum
//   into the sum register and its result into the output register.
// Stall: a held rsp_valid freezes the output register; pixels keep flowing until
//   a completed tile cannot move into the sum register, then req_ready drops.
// Reset: counters clear, tiles_across returns to 140; the sum store needs no
//   clearing since the first pixel of every tile overwrites its entry.
`default_nettype none

module inverted_tile_mean
   import itm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [TC_W-1:0]    tc;
      logic [ROW_W-1:0]   row;
      logic               last;
      logic               first;
      logic               done;
   } stage_type;

   logic [CFG_W-1:0] tiles_ff;
   logic [CNT_W-1:0] col_ff, col_in, col_e;
   logic [CNT_W-1:0] rit_ff, rit_in, rit_e;
   logic [TC_W-1:0]  tcol_ff, tcol_in, tcol_e;
   logic [ROW_W-1:0] trow_ff, trow_in, trow_e;

   logic [TC_W-1:0] tiles_m1;
   logic [TC_W-1:0] tc;
   logic            last, col_end, row_end;
   logic            accept;

   stage_type        a_ff;
   logic             a_valid_ff;
   logic             a_leave;
   logic [SUM_W-1:0] mem [MAX_TILES_ACROSS];
   logic [SUM_W-1:0] rd_ff;
   logic             fwd_ff;
   logic [SUM_W-1:0] fwd_sum_ff;
   logic [SUM_W-1:0] base, sum;

   tile_sum_type c_ff;
   logic         c_valid_ff, c_free;
   rsp_type      mean_out;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff, out_free;

   assign csr_ready = 1'b1;

   // Effective last tile column: zero acts as one, oversize clamps
   always_comb begin
      if (tiles_ff == '0) begin
         tiles_m1 = '0;
      end else if (32'(tiles_ff) > 32'(MAX_TILES_ACROSS)) begin
         tiles_m1 = TC_W'(MAX_TILES_ACROSS - 1);
      end else begin
         tiles_m1 = TC_W'(tiles_ff - CFG_W'(1));
      end
   end

   always_comb begin
      col_e  = req_payload.frame_start ? '0 : col_ff;
      rit_e  = req_payload.frame_start ? '0 : rit_ff;
      tcol_e = req_payload.frame_start ? '0 : tcol_ff;
      trow_e = req_payload.frame_start ? '0 : trow_ff;

      tc      = (tcol_e > tiles_m1) ? tiles_m1 : tcol_e;
      last    = (tc == tiles_m1);
      col_end = (col_e == CNT_W'(TILE_SIZE - 1));
      row_end = (rit_e == CNT_W'(TILE_SIZE - 1));

      col_in  = col_end ? '0 : col_e + CNT_W'(1);
      tcol_in = tc;
      rit_in  = rit_e;
      trow_in = trow_e;
      if (col_end) begin
         if (last) begin
            tcol_in = '0;
            if (row_end) begin
               rit_in  = '0;
               trow_in = trow_e + ROW_W'(1);
            end else begin
               rit_in = rit_e + CNT_W'(1);
            end
         end else begin
            tcol_in = tc + TC_W'(1);
         end
      end
   end

   // Handshake chain
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign c_free    = !c_valid_ff || out_free;
   assign a_leave   = a_valid_ff && (!a_ff.done || c_free);
   assign req_ready = !a_valid_ff || a_leave;
   assign accept    = req_valid && req_ready;

   // Accumulate: bypass the entry written on the same edge this pixel was read
   always_comb begin
      if (a_ff.first) begin
         base = '0;
      end else if (fwd_ff) begin
         base = fwd_sum_ff;
      end else begin
         base = rd_ff;
      end
      sum = base + SUM_W'(a_ff.pixel);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= mem[tc];
      end
      if (a_leave) begin
         mem[a_ff.tc] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiles_ff     <= TILES_RESET;
         col_ff       <= '0;
         rit_ff       <= '0;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         a_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tiles_ff <= csr_data;
         end
         if (accept) begin
            col_ff     <= col_in;
            rit_ff     <= rit_in;
            tcol_ff    <= tcol_in;
            trow_ff    <= trow_in;
            a_valid_ff <= 1'b1;
            fwd_ff     <= a_leave && (a_ff.tc == tc);
         end else if (a_leave) begin
            a_valid_ff <= 1'b0;
         end
         if (a_leave && a_ff.done) begin
            c_valid_ff <= 1'b1;
         end else if (out_free) begin
            c_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff.pixel <= req_payload.pixel;
         a_ff.tc    <= tc;
         a_ff.row   <= trow_e;
         a_ff.last  <= last;
         a_ff.first <= (col_e == '0) && (rit_e == '0);
         a_ff.done  <= col_end && row_end;
         fwd_sum_ff <= sum;
      end
      if (a_leave && a_ff.done) begin
         c_ff.sum    <= sum;
         c_ff.column <= COLUMN_W'(a_ff.tc);
         c_ff.row    <= a_ff.row;
         c_ff.last   <= a_ff.last;
      end
      if (out_free && c_valid_ff) begin
         rsp_ff <= mean_out;
      end
   end

   itm_inv_mean u_inv_mean (
      .tile   (c_ff),
      .result (mean_out)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A completed tile blocked by a full sum stage must stall the input
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_ff.done && c_valid_ff && !out_free |-> !req_ready)
      else $error("input accepted while completed tile is blocked");

   // Every accepted pixel lands in the pixel register
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_valid_ff)
      else $error("accepted pixel lost");

   // A new result only comes from an occupied sum stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(c_valid_ff))
      else $error("result without a completed tile");

   // A tile never completes on its first pixel
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_ff.done |-> !a_ff.first)
      else $error("tile completes on its first pixel");

endmodule

`default_nettype wire

[hw/rtl/itm_inv_mean.sv]
`default_nettype none

module itm_inv_mean
   import itm_pkg::*;
(
   input  tile_sum_type tile,
   output rsp_type      result
);

   logic [SUM_W+RECIP_W-1:0] product;
   logic [MEAN_W-1:0]        mean;
   logic [PIXEL_W-1:0]       mean_sat;

   always_comb begin
      product = (SUM_W+RECIP_W)'(tile.sum) * (SUM_W+RECIP_W)'(RECIP);
      mean    = product[RECIP_K +: MEAN_W];
      if (MEAN_W'(mean) > MEAN_W'(FULL_SCALE)) begin
         mean_sat = FULL_SCALE;
      end else begin
         mean_sat = PIXEL_W'(mean);
      end
      result.tile_value  = FULL_SCALE - mean_sat;
      result.tile_column = tile.column;
      result.tile_row    = tile.row;
      result.row_done    = tile.last;
   end

endmodule

`default_nettype wire

[tb/inverted_tile_mean_test.sv]
`timescale 1ns / 1ps

module inverted_tile_mean_test;
   import itm_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 6;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   // tile geometry tracked from accepted pixels
   logic [CFG_W-1:0] tiles_cfg;
   int unsigned      pix_col;
   int unsigned      tile_col;
   int unsigned      pix_row;
   logic [ROW_W-1:0] band_index;
   int unsigned      column_sums [MAX_TILES_ACROSS];
   rsp_type          expected_tiles [$];

   bit               no_idle;
   int unsigned      stalled_cycles;
   int unsigned      mismatches;
   int unsigned      pixels_sent;
   int unsigned      tiles_checked;
   int unsigned      cfg_writes;

   inverted_tile_mean u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void predict_pixel(input req_type item);
      int unsigned across;
      int unsigned tc;
      int unsigned mean;
      bit          last;
      rsp_type     tile;
      across = (tiles_cfg == 0) ? 1 :
               (tiles_cfg > MAX_TILES_ACROSS) ? MAX_TILES_ACROSS : tiles_cfg;
      if (item.frame_start) begin
         pix_col = 0;
         tile_col = 0;
         pix_row = 0;
         band_index = '0;
      end
      // a column past the (possibly narrowed) row end counts as the last one
      tc = (tile_col >= across) ? across - 1 : tile_col;
      last = (tc == across - 1);
      if (pix_col == 0 && pix_row == 0)
         column_sums[tc] = item.pixel;
      else
         column_sums[tc] += item.pixel;
      if (pix_col + 1 >= TILE_SIZE && pix_row + 1 >= TILE_SIZE) begin
         mean = column_sums[tc] / TILE_AREA;
         if (mean > 255)
            mean = 255;
         tile.tile_value = PIXEL_W'(255 - mean);
         tile.tile_column = COLUMN_W'(tc);
         tile.tile_row = band_index;
         tile.row_done = last;
         expected_tiles.push_back(tile);
      end
      pix_col++;
      if (pix_col >= TILE_SIZE) begin
         pix_col = 0;
         if (last) begin
            tile_col = 0;
            pix_row++;
            if (pix_row >= TILE_SIZE) begin
               pix_row = 0;
               band_index = band_index + 1'b1;
            end
         end else begin
            tile_col = tc + 1;
         end
      end else begin
         tile_col = tc;
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // all helpers start and end at a falling edge
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      req_type item;
      item.pixel = pix;
      item.frame_start = fs;
      if (!no_idle && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_pixel(item);
      pixels_sent++;
      @(negedge clock);
   endtask

   // hold off until every tile has come out and no pixel is left in the pipe
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tiles.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_tiles_across(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      tiles_cfg = value;
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // raster frame of whole tiles; a noisy frame is cut short or restarted midway
   task automatic send_frame(input int unsigned across, input int unsigned bands,
                             input bit noisy);
      int unsigned total;
      int unsigned cut;
      int unsigned stray;
      total = across * TILE_AREA * bands;
      cut = total;
      stray = total;
      if (noisy) begin
         if ($urandom_range(1))
            cut = $urandom_range(total - 1, 1);
         else
            stray = $urandom_range(total - 1, 1);
      end
      for (int unsigned i = 0; i < cut; i++)
         send_pixel(random_pixel(), i == 0 || i == stray);
   endtask

   // a few pixels at the reset width, then narrow to one tile mid-row
   task automatic test_reset_then_narrow();
      for (int i = 0; i < 12; i++)
         send_pixel(PIXEL_W'($urandom_range(255)), 1'b0);
      write_tiles_across(CFG_W'(1));
      for (int i = 0; i < 23; i++)
         send_pixel(PIXEL_W'($urandom_range(255)), 1'b0);
   endtask

   task automatic test_full_scale_tiles();
      write_tiles_across(CFG_W'(2));
      for (int i = 0; i < 2 * TILE_AREA; i++)
         send_pixel((i % 10) < 5 ? 8'hff : 8'h00, i == 0);
   endtask

   task automatic test_width_limits();
      write_tiles_across('0);
      send_frame(1, 1, 1'b0);
      write_tiles_across('1);
      for (int i = 0; i < 30; i++)
         send_pixel(random_pixel(), i == 0);
      write_tiles_across(CFG_W'(MAX_TILES_ACROSS));
      for (int i = 0; i < 30; i++)
         send_pixel(random_pixel(), i == 0);
   endtask

   task automatic test_narrow_mid_row();
      write_tiles_across(CFG_W'(4));
      for (int i = 0; i < 17; i++)
         send_pixel(random_pixel(), i == 0);
      write_tiles_across(CFG_W'(2));
      for (int i = 0; i < 150; i++)
         send_pixel(random_pixel(), 1'b0);
   endtask

   task automatic test_frame_restart();
      write_tiles_across(CFG_W'(2));
      for (int i = 0; i < 13; i++)
         send_pixel(random_pixel(), i == 0);
      send_frame(2, 1, 1'b0);
   endtask

   // a few single-tile bands sent with no idling on either side
   task automatic test_steady_stream();
      write_tiles_across(CFG_W'(1));
      no_idle = 1'b1;
      for (int i = 0; i < 4 * TILE_AREA; i++)
         send_pixel(PIXEL_W'($urandom_range(255)), i == 0);
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned first_pixel;
      int unsigned first_tile;
      int unsigned across;
      first_pixel = pixels_sent;
      first_tile = tiles_checked + expected_tiles.size();
      while (pixels_sent - first_pixel < 100 ||
             tiles_checked + expected_tiles.size() - first_tile < 4) begin
         across = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
         write_tiles_across(CFG_W'(across));
         send_frame(across, $urandom_range(3, 1), $urandom_range(9) == 0);
         if ($urandom_range(99) < 30)
            wait_drained();
      end
   endtask

   always @(negedge clock)
      rsp_ready <= no_idle || ($urandom_range(99) >= 8);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tiles.size() == 0) begin
            $display("%0t: tile result with none expected, got %p", $time, rsp_payload);
            mismatches++;
         end else begin
            want = expected_tiles.pop_front();
            check_field("tile_value", want.tile_value, rsp_payload.tile_value);
            check_field("tile_column", want.tile_column, rsp_payload.tile_column);
            check_field("tile_row", want.tile_row, rsp_payload.tile_row);
            check_field("row_done", want.row_done, rsp_payload.row_done);
            tiles_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      no_idle = 1'b0;
      stalled_cycles = 0;
      mismatches = 0;
      pixels_sent = 0;
      tiles_checked = 0;
      cfg_writes = 0;
      tiles_cfg = TILES_RESET;
      pix_col = 0;
      tile_col = 0;
      pix_row = 0;
      band_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_then_narrow();
      test_full_scale_tiles();
      test_width_limits();
      test_narrow_mid_row();
      test_frame_restart();
      test_steady_stream();
      test_random_frames();

      wait_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d pixels, checked %0d tiles over %0d width settings", pixels_sent,
               tiles_checked, cfg_writes);
      $display("Widths 0 to 511, narrowing mid-row, frame restarts and an unbroken stream");
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/itm_pkg.sv
hw/rtl/itm_inv_mean.sv
hw/rtl/inverted_tile_mean.sv
tb/inverted_tile_mean_test.sv
